/* hw/rtl/eul_rot_pkg.sv */
// eul_rot_pkg: shared types and constants for the euler angle rotation matrix block
// holds the beat structs, cordic lane type, arctangent table and fixed datapath widths
// no dependencies
package eul_rot_pkg;

    // default parameter values
    localparam int ANGLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 15;

    // cordic over a 32-bit binary angle, q30 values
    localparam int CORDIC_STAGES = 30;
    localparam int ANG_W         = 32;
    localparam int VAL_W         = 33;
    localparam int ZW            = 34;
    localparam int PROD_W        = 2 * VAL_W;
    localparam int SUM_W         = PROD_W + 2;
    localparam int OUT_W         = 16;
    localparam int IN_W          = 16;

    // lane numbering inside a cordic trio
    localparam int LANE_ROLL  = 0;
    localparam int LANE_PITCH = 1;
    localparam int LANE_YAW   = 2;
    localparam int NUM_LANES  = 3;

    localparam logic signed [VAL_W-1:0] CORDIC_GAIN = 33'sh0_26DD_3B6A;

    // arctangent of 2^-i as a fraction of a full turn (2^32)
    localparam logic [ANG_W-1:0] ATAN_TURN [CORDIC_STAGES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    // input beat
    typedef struct packed {
        logic [IN_W-1:0] roll_angle;
        logic [IN_W-1:0] pitch_angle;
        logic [IN_W-1:0] yaw_angle;
    } angles_t;

    // result beat
    typedef struct packed {
        logic signed [OUT_W-1:0] r00;
        logic signed [OUT_W-1:0] r01;
        logic signed [OUT_W-1:0] r02;
        logic signed [OUT_W-1:0] r10;
        logic signed [OUT_W-1:0] r11;
        logic signed [OUT_W-1:0] r12;
        logic signed [OUT_W-1:0] r20;
        logic signed [OUT_W-1:0] r21;
        logic signed [OUT_W-1:0] r22;
    } matrix_t;

    // one rotation lane in flight
    typedef struct packed {
        logic signed [VAL_W-1:0] x;
        logic signed [VAL_W-1:0] y;
        logic signed [ZW-1:0]    z;
        logic                    flip;
    } cordic_lane_t;

    typedef cordic_lane_t [NUM_LANES-1:0] cordic_trio_t;

endpackage

/* hw/rtl/euler_angles_to_rotation_matrix.sv */
// euler_angles_to_rotation_matrix: roll/pitch/yaw binary angles to a 3x3 rotation matrix
// three pipelined 30-step rotation cordics, then a registered multiply and sum tree
// depends on eul_rot_pkg
//
// usage
//   s_valid/s_ready/s_data carry one beat of three binary angles (a full turn is
//   2^ANGLE_BITS); m_valid/m_ready/m_data carry the nine q1.15 matrix entries.
//   one beat is accepted per cycle and one result leaves per cycle when m_ready
//   stays high; the rate is set by the fully pipelined cordic, one rotation step
//   per register stage, and the multiply stages behind it.
//   the accepted beat passes these registers in order before m_valid rises
//   (1 prep, 30 cordic, trig, product, rounding, triple product, sum, output).
//   reset (aresetn low, synchronous) clears every valid bit; no result is
//   pending afterwards and s_ready is high.
//   when the receiver stalls, the output register holds its beat and one more
//   result drops into a skid register; once that is full the whole pipeline
//   freezes and s_ready goes low, so nothing is lost or repeated.
//   entries of +1.0 or more saturate to 2^FRAC_BITS-1.
module euler_angles_to_rotation_matrix #(
    parameter int ANGLE_BITS = eul_rot_pkg::ANGLE_BITS_DEF,
    parameter int FRAC_BITS  = eul_rot_pkg::FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  eul_rot_pkg::angles_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output eul_rot_pkg::matrix_t  m_data
);
    import eul_rot_pkg::*;

    localparam int unsigned ANG_SHIFT = ANG_W - ANGLE_BITS;
    localparam logic [ANG_W-1:0] ANG_MASK = ANG_W'((64'd1 << ANGLE_BITS) - 64'd1);
    localparam int unsigned S60 = 60 - FRAC_BITS;
    localparam int unsigned S30 = 30 - FRAC_BITS;
    localparam logic signed [PROD_W-1:0] Q30_HALF = PROD_W'(64'd1 << 29);
    localparam logic signed [SUM_W-1:0] SAT_HI =
        (SUM_W'(1) << FRAC_BITS) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

    // round half up by n bits, then clamp to the fraction range
    function automatic logic signed [OUT_W-1:0] round_sat(
        input logic signed [SUM_W-1:0] v,
        input int unsigned             n
    );
        logic signed [SUM_W-1:0] half;
        logic signed [SUM_W-1:0] r;
        half = '0;
        if (n != 0) begin
            half = SUM_W'(1) << (n - 1);
        end
        r = (v + half) >>> n;
        if (r > SAT_HI) begin
            r = SAT_HI;
        end else if (r < SAT_LO) begin
            r = SAT_LO;
        end
        return r[OUT_W-1:0];
    endfunction

    // pipeline advance: frozen only while the skid register holds a beat
    logic en;
    logic skid_valid_reg;
    assign en      = !skid_valid_reg;
    assign s_ready = en;

    // ---------------------------------------------------------------
    // prep: binary angle to 32-bit turn, fold into [-90, 90) degrees
    // ---------------------------------------------------------------
    logic [IN_W-1:0]   ang_in [NUM_LANES];
    cordic_trio_t      cord_next [CORDIC_STAGES+1];
    cordic_trio_t      cord_reg  [CORDIC_STAGES+1];
    logic [CORDIC_STAGES:0] cord_valid_reg;

    assign ang_in[LANE_ROLL]  = s_data.roll_angle;
    assign ang_in[LANE_PITCH] = s_data.pitch_angle;
    assign ang_in[LANE_YAW]   = s_data.yaw_angle;

    for (genvar l = 0; l < NUM_LANES; l++) begin : g_prep
        logic [ANG_W-1:0] t_base;
        logic [ANG_W-1:0] t_quad;
        logic [ANG_W-1:0] t_fold;
        logic             flip;

        assign t_base = (ANG_W'(ang_in[l]) & ANG_MASK) << ANG_SHIFT;
        assign t_quad = t_base + 32'h4000_0000;
        assign flip   = t_quad[ANG_W-1];
        assign t_fold = flip ? (t_base + 32'h8000_0000) : t_base;

        assign cord_next[0][l].x    = CORDIC_GAIN;
        assign cord_next[0][l].y    = '0;
        assign cord_next[0][l].z    = {{(ZW-ANG_W){t_fold[ANG_W-1]}}, t_fold};
        assign cord_next[0][l].flip = flip;
    end

    // ---------------------------------------------------------------
    // cordic: one rotation step per register stage, three lanes each
    // ---------------------------------------------------------------
    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cord
        for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
            logic signed [VAL_W-1:0] cur_x;
            logic signed [VAL_W-1:0] cur_y;
            logic signed [ZW-1:0]    cur_z;
            logic signed [VAL_W-1:0] dx;
            logic signed [VAL_W-1:0] dy;
            logic signed [ZW-1:0]    atan_z;

            assign cur_x  = cord_reg[g][l].x;
            assign cur_y  = cord_reg[g][l].y;
            assign cur_z  = cord_reg[g][l].z;
            assign dx     = cur_y >>> g;
            assign dy     = cur_x >>> g;
            assign atan_z = {{(ZW-ANG_W){1'b0}}, ATAN_TURN[g]};

            always_comb begin
                cord_next[g+1][l].flip = cord_reg[g][l].flip;
                if (!cur_z[ZW-1]) begin
                    cord_next[g+1][l].x = cur_x - dx;
                    cord_next[g+1][l].y = cur_y + dy;
                    cord_next[g+1][l].z = cur_z - atan_z;
                end else begin
                    cord_next[g+1][l].x = cur_x + dx;
                    cord_next[g+1][l].y = cur_y - dy;
                    cord_next[g+1][l].z = cur_z + atan_z;
                end
            end
        end
    end

    // cordic payload registers, prep stage included
    for (genvar g = 0; g <= CORDIC_STAGES; g++) begin : g_cord_reg
        always_ff @(posedge aclk) begin
            if (en) begin
                cord_reg[g] <= cord_next[g];
            end
        end
    end

    // ---------------------------------------------------------------
    // trig: undo the half-turn fold
    // ---------------------------------------------------------------
    logic signed [VAL_W-1:0] sin_next [NUM_LANES];
    logic signed [VAL_W-1:0] cos_next [NUM_LANES];
    logic signed [VAL_W-1:0] sin_reg  [NUM_LANES];
    logic signed [VAL_W-1:0] cos_reg  [NUM_LANES];
    logic                    trig_valid_reg;

    for (genvar l = 0; l < NUM_LANES; l++) begin : g_trig
        assign sin_next[l] = cord_reg[CORDIC_STAGES][l].flip ?
                             -cord_reg[CORDIC_STAGES][l].y : cord_reg[CORDIC_STAGES][l].y;
        assign cos_next[l] = cord_reg[CORDIC_STAGES][l].flip ?
                             -cord_reg[CORDIC_STAGES][l].x : cord_reg[CORDIC_STAGES][l].x;

        always_ff @(posedge aclk) begin
            if (en) begin
                sin_reg[l] <= sin_next[l];
                cos_reg[l] <= cos_next[l];
            end
        end
    end

    // ---------------------------------------------------------------
    // products of two factors, q60
    // ---------------------------------------------------------------
    logic signed [VAL_W-1:0]  sr, cr, sp, cp, sy, cy;
    logic signed [PROD_W-1:0] p_srsp_reg, p_crsp_reg, p_cpcy_reg, p_cpsy_reg;
    logic signed [PROD_W-1:0] p_srcp_reg, p_crcp_reg, p_crsy_reg, p_crcy_reg;
    logic signed [PROD_W-1:0] p_srsy_reg, p_srcy_reg;
    logic signed [VAL_W-1:0]  p_sp_reg, p_sy_reg, p_cy_reg;
    logic                     prod_valid_reg;

    assign sr = sin_reg[LANE_ROLL];
    assign cr = cos_reg[LANE_ROLL];
    assign sp = sin_reg[LANE_PITCH];
    assign cp = cos_reg[LANE_PITCH];
    assign sy = sin_reg[LANE_YAW];
    assign cy = cos_reg[LANE_YAW];

    always_ff @(posedge aclk) begin
        if (en) begin
            p_srsp_reg <= sr * sp;
            p_crsp_reg <= cr * sp;
            p_cpcy_reg <= cp * cy;
            p_cpsy_reg <= cp * sy;
            p_srcp_reg <= sr * cp;
            p_crcp_reg <= cr * cp;
            p_crsy_reg <= cr * sy;
            p_crcy_reg <= cr * cy;
            p_srsy_reg <= sr * sy;
            p_srcy_reg <= sr * cy;
            p_sp_reg   <= sp;
            p_sy_reg   <= sy;
            p_cy_reg   <= cy;
        end
    end

    // ---------------------------------------------------------------
    // round sr*sp and cr*sp back to q30
    // ---------------------------------------------------------------
    logic signed [PROD_W-1:0] srsp_wide, crsp_wide;
    logic signed [VAL_W-1:0]  q_srsp_reg, q_crsp_reg, q_sp_reg, q_sy_reg, q_cy_reg;
    logic signed [PROD_W-1:0] q_cpcy_reg, q_cpsy_reg, q_srcp_reg, q_crcp_reg;
    logic signed [PROD_W-1:0] q_crsy_reg, q_crcy_reg, q_srsy_reg, q_srcy_reg;
    logic                     rnd_valid_reg;

    assign srsp_wide = (p_srsp_reg + Q30_HALF) >>> 30;
    assign crsp_wide = (p_crsp_reg + Q30_HALF) >>> 30;

    always_ff @(posedge aclk) begin
        if (en) begin
            q_srsp_reg <= srsp_wide[VAL_W-1:0];
            q_crsp_reg <= crsp_wide[VAL_W-1:0];
            q_sp_reg   <= p_sp_reg;
            q_sy_reg   <= p_sy_reg;
            q_cy_reg   <= p_cy_reg;
            q_cpcy_reg <= p_cpcy_reg;
            q_cpsy_reg <= p_cpsy_reg;
            q_srcp_reg <= p_srcp_reg;
            q_crcp_reg <= p_crcp_reg;
            q_crsy_reg <= p_crsy_reg;
            q_crcy_reg <= p_crcy_reg;
            q_srsy_reg <= p_srsy_reg;
            q_srcy_reg <= p_srcy_reg;
        end
    end

    // ---------------------------------------------------------------
    // triple products, q60
    // ---------------------------------------------------------------
    logic signed [PROD_W-1:0] t_srspcy_reg, t_srspsy_reg, t_crspcy_reg, t_crspsy_reg;
    logic signed [PROD_W-1:0] t_cpcy_reg, t_cpsy_reg, t_srcp_reg, t_crcp_reg;
    logic signed [PROD_W-1:0] t_crsy_reg, t_crcy_reg, t_srsy_reg, t_srcy_reg;
    logic signed [VAL_W-1:0]  t_sp_reg;
    logic                     trip_valid_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            t_srspcy_reg <= q_srsp_reg * q_cy_reg;
            t_srspsy_reg <= q_srsp_reg * q_sy_reg;
            t_crspcy_reg <= q_crsp_reg * q_cy_reg;
            t_crspsy_reg <= q_crsp_reg * q_sy_reg;
            t_cpcy_reg   <= q_cpcy_reg;
            t_cpsy_reg   <= q_cpsy_reg;
            t_srcp_reg   <= q_srcp_reg;
            t_crcp_reg   <= q_crcp_reg;
            t_crsy_reg   <= q_crsy_reg;
            t_crcy_reg   <= q_crcy_reg;
            t_srsy_reg   <= q_srsy_reg;
            t_srcy_reg   <= q_srcy_reg;
            t_sp_reg     <= q_sp_reg;
        end
    end

    // ---------------------------------------------------------------
    // sums of the mixed entries, q60; the other entries pass through, r02 in q30
    // ---------------------------------------------------------------
    logic signed [SUM_W-1:0] s_r10_reg, s_r11_reg, s_r20_reg, s_r21_reg;
    logic signed [SUM_W-1:0] s_r00_reg, s_r01_reg, s_r12_reg, s_r22_reg;
    logic signed [SUM_W-1:0] s_r02_reg;
    logic                    sum_valid_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s_r10_reg <= SUM_W'(t_srspcy_reg) - SUM_W'(t_crsy_reg);
            s_r11_reg <= SUM_W'(t_srspsy_reg) + SUM_W'(t_crcy_reg);
            s_r20_reg <= SUM_W'(t_crspcy_reg) + SUM_W'(t_srsy_reg);
            s_r21_reg <= SUM_W'(t_crspsy_reg) - SUM_W'(t_srcy_reg);
            s_r00_reg <= SUM_W'(t_cpcy_reg);
            s_r01_reg <= SUM_W'(t_cpsy_reg);
            s_r12_reg <= SUM_W'(t_srcp_reg);
            s_r22_reg <= SUM_W'(t_crcp_reg);
            s_r02_reg <= -SUM_W'(t_sp_reg);
        end
    end

    // ---------------------------------------------------------------
    // final rounding and saturation
    // ---------------------------------------------------------------
    matrix_t last_data;

    assign last_data.r00 = round_sat(s_r00_reg, S60);
    assign last_data.r01 = round_sat(s_r01_reg, S60);
    assign last_data.r02 = round_sat(s_r02_reg, S30);
    assign last_data.r10 = round_sat(s_r10_reg, S60);
    assign last_data.r11 = round_sat(s_r11_reg, S60);
    assign last_data.r12 = round_sat(s_r12_reg, S60);
    assign last_data.r20 = round_sat(s_r20_reg, S60);
    assign last_data.r21 = round_sat(s_r21_reg, S60);
    assign last_data.r22 = round_sat(s_r22_reg, S60);

    // valid bits travel with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cord_valid_reg <= '0;
            trig_valid_reg <= 1'b0;
            prod_valid_reg <= 1'b0;
            rnd_valid_reg  <= 1'b0;
            trip_valid_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
        end else if (en) begin
            cord_valid_reg <= {cord_valid_reg[CORDIC_STAGES-1:0], s_valid};
            trig_valid_reg <= cord_valid_reg[CORDIC_STAGES];
            prod_valid_reg <= trig_valid_reg;
            rnd_valid_reg  <= prod_valid_reg;
            trip_valid_reg <= rnd_valid_reg;
            sum_valid_reg  <= trip_valid_reg;
        end
    end

    // ---------------------------------------------------------------
    // output register with skid
    // ---------------------------------------------------------------
    logic    m_valid_reg, m_valid_next, skid_valid_next;
    logic    out_take;
    matrix_t m_data_reg, m_data_next, skid_data_reg, skid_data_next;

    assign out_take = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_take) begin
            if (skid_valid_reg) begin
                m_valid_next    = 1'b1;
                m_data_next     = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                m_valid_next = sum_valid_reg;
                m_data_next  = last_data;
            end
        end else if (en && sum_valid_reg) begin
            skid_valid_next = 1'b1;
            skid_data_next  = last_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg    <= m_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    logic [CORDIC_STAGES+5:0] pipe_valid;
    assign pipe_valid = {cord_valid_reg, trig_valid_reg, prod_valid_reg,
                         rnd_valid_reg, trip_valid_reg, sum_valid_reg};

    // skid only fills behind a stalled output beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && !$past(skid_valid_reg) |-> $past(m_valid_reg && !m_ready))
        else $error("skid filled without an output stall");

    // a frozen pipeline always has a result on offer
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid_reg)
        else $error("input back-pressure without a pending result");

    // while frozen no stage gains or loses a beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        !en && $past(aresetn) |=> $stable(pipe_valid))
        else $error("pipeline moved while stalled");

    // cordic residual angle has converged at the last step
    assert property (@(posedge aclk) disable iff (!aresetn)
        cord_valid_reg[CORDIC_STAGES] |->
            (cord_reg[CORDIC_STAGES][LANE_ROLL].z  > -34'sd1024 &&
             cord_reg[CORDIC_STAGES][LANE_ROLL].z  <  34'sd1024 &&
             cord_reg[CORDIC_STAGES][LANE_PITCH].z > -34'sd1024 &&
             cord_reg[CORDIC_STAGES][LANE_PITCH].z <  34'sd1024 &&
             cord_reg[CORDIC_STAGES][LANE_YAW].z   > -34'sd1024 &&
             cord_reg[CORDIC_STAGES][LANE_YAW].z   <  34'sd1024))
        else $error("cordic residual angle out of range");

endmodule
